/* rtl/kuz_pkg.sv */
// Package for the Kuznyechik cipher core: S-box table, linear transform L in R steps,
// GF(2^8) arithmetic and the request/result payload structs.
// No dependencies.
package kuz_pkg;

    localparam int KEY_COUNT   = 10;
    localparam int ROUNDS      = 9;
    localparam int STORE_DEPTH = 2 * KEY_COUNT;
    localparam int STORE_AW    = $clog2(STORE_DEPTH);

    typedef enum logic [1:0] {
        CFG_KEY0 = 2'd0,
        CFG_KEY1 = 2'd1,
        CFG_KEY2 = 2'd2,
        CFG_KEY3 = 2'd3
    } cfg_index_t;

    typedef struct packed {
        logic        op;
        logic [63:0] block_in_low;
        logic [63:0] block_in_high;
    } request_t;

    typedef struct packed {
        logic [63:0] block_out_low;
        logic [63:0] block_out_high;
    } result_t;

    localparam logic [7:0] SBOX [256] = '{
        8'd252, 8'd238, 8'd221, 8'd17, 8'd207, 8'd110, 8'd49, 8'd22,
        8'd251, 8'd196, 8'd250, 8'd218, 8'd35, 8'd197, 8'd4, 8'd77,
        8'd233, 8'd119, 8'd240, 8'd219, 8'd147, 8'd46, 8'd153, 8'd186,
        8'd23, 8'd54, 8'd241, 8'd187, 8'd20, 8'd205, 8'd95, 8'd193,
        8'd249, 8'd24, 8'd101, 8'd90, 8'd226, 8'd92, 8'd239, 8'd33,
        8'd129, 8'd28, 8'd60, 8'd66, 8'd139, 8'd1, 8'd142, 8'd79,
        8'd5, 8'd132, 8'd2, 8'd174, 8'd227, 8'd106, 8'd143, 8'd160,
        8'd6, 8'd11, 8'd237, 8'd152, 8'd127, 8'd212, 8'd211, 8'd31,
        8'd235, 8'd52, 8'd44, 8'd81, 8'd234, 8'd200, 8'd72, 8'd171,
        8'd242, 8'd42, 8'd104, 8'd162, 8'd253, 8'd58, 8'd206, 8'd204,
        8'd181, 8'd112, 8'd14, 8'd86, 8'd8, 8'd12, 8'd118, 8'd18,
        8'd191, 8'd114, 8'd19, 8'd71, 8'd156, 8'd183, 8'd93, 8'd135,
        8'd21, 8'd161, 8'd150, 8'd41, 8'd16, 8'd123, 8'd154, 8'd199,
        8'd243, 8'd145, 8'd120, 8'd111, 8'd157, 8'd158, 8'd178, 8'd177,
        8'd50, 8'd117, 8'd25, 8'd61, 8'd255, 8'd53, 8'd138, 8'd126,
        8'd109, 8'd84, 8'd198, 8'd128, 8'd195, 8'd189, 8'd13, 8'd87,
        8'd223, 8'd245, 8'd36, 8'd169, 8'd62, 8'd168, 8'd67, 8'd201,
        8'd215, 8'd121, 8'd214, 8'd246, 8'd124, 8'd34, 8'd185, 8'd3,
        8'd224, 8'd15, 8'd236, 8'd222, 8'd122, 8'd148, 8'd176, 8'd188,
        8'd220, 8'd232, 8'd40, 8'd80, 8'd78, 8'd51, 8'd10, 8'd74,
        8'd167, 8'd151, 8'd96, 8'd115, 8'd30, 8'd0, 8'd98, 8'd68,
        8'd26, 8'd184, 8'd56, 8'd130, 8'd100, 8'd159, 8'd38, 8'd65,
        8'd173, 8'd69, 8'd70, 8'd146, 8'd39, 8'd94, 8'd85, 8'd47,
        8'd140, 8'd163, 8'd165, 8'd125, 8'd105, 8'd213, 8'd149, 8'd59,
        8'd7, 8'd88, 8'd179, 8'd64, 8'd134, 8'd172, 8'd29, 8'd247,
        8'd48, 8'd55, 8'd107, 8'd228, 8'd136, 8'd217, 8'd231, 8'd137,
        8'd225, 8'd27, 8'd131, 8'd73, 8'd76, 8'd63, 8'd248, 8'd254,
        8'd141, 8'd83, 8'd170, 8'd144, 8'd202, 8'd216, 8'd133, 8'd97,
        8'd32, 8'd113, 8'd103, 8'd164, 8'd45, 8'd43, 8'd9, 8'd91,
        8'd203, 8'd155, 8'd37, 8'd208, 8'd190, 8'd229, 8'd108, 8'd82,
        8'd89, 8'd166, 8'd116, 8'd210, 8'd230, 8'd244, 8'd180, 8'd192,
        8'd209, 8'd102, 8'd175, 8'd194, 8'd57, 8'd75, 8'd99, 8'd182
    };

    localparam logic [7:0] LCOEF [16] = '{
        8'd1, 8'd148, 8'd32, 8'd133, 8'd16, 8'd194, 8'd192, 8'd1,
        8'd251, 8'd1, 8'd192, 8'd194, 8'd16, 8'd133, 8'd32, 8'd148
    };

    // GF(2^8) multiply, polynomial x^8+x^7+x^6+x+1
    function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] r;
        logic [7:0] x;
        r = '0;
        x = a;
        for (int i = 0; i < 8; i++) begin
            if (b[i]) r = r ^ x;
            x = x[7] ? ((x << 1) ^ 8'hC3) : (x << 1);
        end
        return r;
    endfunction

    function automatic logic [7:0] lin_fn(input logic [127:0] v);
        logic [7:0] acc;
        acc = '0;
        for (int i = 0; i < 16; i++) acc = acc ^ gf_mul(v[8*i +: 8], LCOEF[i]);
        return acc;
    endfunction

    function automatic logic [127:0] sub_fwd(input logic [127:0] v);
        logic [127:0] r;
        for (int i = 0; i < 16; i++) r[8*i +: 8] = SBOX[v[8*i +: 8]];
        return r;
    endfunction

    function automatic logic [7:0] sbox_inv_byte(input logic [7:0] y);
        logic [7:0] r;
        r = '0;
        for (int x = 0; x < 256; x++)
            if (SBOX[x] == y) r = 8'(x);
        return r;
    endfunction

    function automatic logic [127:0] sub_inv(input logic [127:0] v);
        logic [127:0] r;
        for (int i = 0; i < 16; i++) r[8*i +: 8] = sbox_inv_byte(v[8*i +: 8]);
        return r;
    endfunction

    // one step of the L register: shift down, new top byte = l(v)
    function automatic logic [127:0] r_fwd(input logic [127:0] v);
        return {lin_fn(v), v[127:8]};
    endfunction

    function automatic logic [127:0] r_inv(input logic [127:0] v);
        logic [127:0] t;
        t = {v[119:0], v[127:120]};
        return {t[127:8], lin_fn(t)};
    endfunction

endpackage

/* rtl/kuz_ram.sv */
// Generic single-port-write RAM with registered read.
// No dependencies.
module kuz_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 20
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we) mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end
endmodule

/* rtl/kuz_lstep.sv */
// L-transform engine: sixteen R steps, four per cycle, forward or inverse.
// Depends on kuz_pkg.
module kuz_lstep (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           go,
    input  logic           inv,
    input  logic [127:0]   din,
    output logic           done,
    output logic [127:0]   dout
);
    logic [127:0] v_reg;
    logic [127:0] v_next;
    logic [2:0]   cnt_reg;
    logic         inv_reg;

    always_comb
    begin
        v_next = v_reg;
        for (int i = 0; i < 4; i++)
            v_next = inv_reg ? kuz_pkg::r_inv(v_next) : kuz_pkg::r_fwd(v_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (go)
        begin
            cnt_reg <= 3'd4;
        end
        else if (cnt_reg != '0)
        begin
            cnt_reg <= cnt_reg - 3'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (go)
        begin
            v_reg   <= din;
            inv_reg <= inv;
        end
        else if (cnt_reg != '0)
        begin
            v_reg <= v_next;
        end
    end

    assign done = (cnt_reg == 3'd1);
    assign dout = v_next;
endmodule

/* rtl/kuznyechik_block_cipher.sv */
// Kuznyechik (GOST R 34.12-2015) 128-bit block cipher core, top level; uses kuz_pkg, kuz_ram, kuz_lstep.
// With keys present, each of the nine rounds reads the two key words (S_RD0, S_RD1), XORs the
// key and starts L (S_LGO) and waits for L (S_LWAIT); a final key XOR in S_LGO follows, then
// the strobe. A request after reset or after a key write first expands the keys: 32 Feistel
// steps (S_KC, S_KCW, S_KF, S_KFW) and 20 store writes in S_KWR.
// A new request is taken only in idle, while busy is low; the receiver cannot stall.
// Reset clears control state and the key registers; the key store is undefined until expanded.
module kuznyechik_block_cipher (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  kuz_pkg::request_t request,
    output logic              strobe,
    output kuz_pkg::result_t  result,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [1:0]        cfg_index,
    input  logic [63:0]       cfg_data
);
    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001,
        S_KWR   = 10'b0000000010,  // write both key halves to the store, four words
        S_KC    = 10'b0000000100,  // start L on the step number plus one: round constant
        S_KCW   = 10'b0000001000,  // wait for the constant
        S_KF    = 10'b0000010000,  // start L on S(half ^ constant)
        S_KFW   = 10'b0000100000,  // wait for L, fold into the other half
        S_RD0   = 10'b0001000000,  // read the low round key word
        S_RD1   = 10'b0010000000,  // read the high word, hold the low one
        S_LGO   = 10'b0100000000,  // key XOR, then start L or finish
        S_LWAIT = 10'b1000000000   // L running
    } state_t;

    state_t         state_reg, state_next;
    logic [63:0]    key_reg [4];
    logic           kvalid_reg;
    logic [127:0]   h0_reg, h1_reg;   // key halves during expansion
    logic [127:0]   c_reg;            // round constant of the current Feistel step
    logic [5:0]     step_reg;         // Feistel step 0..32
    logic [1:0]     wcnt_reg;         // store write counter
    logic [3:0]     round_reg;
    logic [127:0]   blk_reg;
    logic           op_reg;
    logic [63:0]    klo_reg;
    logic           strobe_reg;
    logic           strobe_next;

    // store signals
    logic                         we;
    logic [kuz_pkg::STORE_AW-1:0] waddr, raddr;
    logic [63:0]                  wdata, rdata;

    // L unit
    logic         l_go, l_inv, l_done;
    logic [127:0] l_din, l_dout;

    logic         accept;
    logic         last_round;
    logic [3:0]   kidx;
    logic [127:0] rkey;
    logic [127:0] kin;
    logic [7:0]   cnum;

    kuz_ram #(.WIDTH(64), .DEPTH(kuz_pkg::STORE_DEPTH)) u_store (
        .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
        .raddr(raddr), .rdata(rdata)
    );

    kuz_lstep u_l (
        .clk(clk), .rst_n(rst_n), .go(l_go), .inv(l_inv), .din(l_din),
        .done(l_done), .dout(l_dout)
    );

    // A key write waits while a request is being presented, so the request goes first.
    assign accept    = start && (state_reg == S_IDLE);
    assign busy      = (state_reg != S_IDLE);
    assign cfg_ready = (state_reg == S_IDLE) && !start;
    assign strobe    = strobe_reg;

    // key index for this round; encrypt walks up, decrypt down
    assign kidx       = op_reg ? 4'(kuz_pkg::KEY_COUNT - 1) - round_reg : round_reg;
    assign last_round = (round_reg == 4'(kuz_pkg::ROUNDS));
    assign rkey       = {rdata, klo_reg};
    assign kin        = blk_reg ^ rkey;
    // Feistel step n uses the constant L(n + 1)
    assign cnum       = {2'b00, step_reg} + 8'd1;

    always_comb
    begin
        we          = 1'b0;
        waddr       = {step_reg[5:3], wcnt_reg};
        wdata       = h0_reg[63:0];
        raddr       = {kidx, 1'b0};
        l_go        = 1'b0;
        l_inv       = op_reg;
        l_din       = kin;
        strobe_next = 1'b0;
        state_next  = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start) state_next = kvalid_reg ? S_RD0 : S_KWR;
            end
            S_KWR:
            begin
                we = 1'b1;
                case (wcnt_reg)
                    2'd0:    wdata = h0_reg[63:0];
                    2'd1:    wdata = h0_reg[127:64];
                    2'd2:    wdata = h1_reg[63:0];
                    default: wdata = h1_reg[127:64];
                endcase
                if (wcnt_reg == 2'd3)
                    state_next = (step_reg == 6'(4 * (kuz_pkg::KEY_COUNT - 2))) ? S_RD0 : S_KC;
            end
            S_KC:
            begin
                l_go  = 1'b1;
                l_inv = 1'b0;
                l_din = {120'd0, cnum};
                state_next = S_KCW;
            end
            S_KCW:
            begin
                if (l_done) state_next = S_KF;
            end
            S_KF:
            begin
                l_go  = 1'b1;
                l_inv = 1'b0;
                l_din = kuz_pkg::sub_fwd((step_reg[0] ? h1_reg : h0_reg) ^ c_reg);
                state_next = S_KFW;
            end
            S_KFW:
            begin
                // every eighth step closes a pair of round keys
                if (l_done) state_next = (step_reg[2:0] == 3'd7) ? S_KWR : S_KC;
            end
            S_RD0:
            begin
                state_next = S_RD1;
            end
            S_RD1:
            begin
                raddr      = {kidx, 1'b1};
                state_next = S_LGO;
            end
            S_LGO:
            begin
                if (last_round)
                begin
                    strobe_next = 1'b1;
                    state_next  = S_IDLE;
                end
                else
                begin
                    // encrypt: S then L; decrypt: inverse L now, inverse S on the way out
                    l_go  = 1'b1;
                    l_din = op_reg ? kin : kuz_pkg::sub_fwd(kin);
                    state_next = S_LWAIT;
                end
            end
            S_LWAIT:
            begin
                if (l_done) state_next = S_RD0;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            kvalid_reg <= 1'b0;
            step_reg   <= '0;
            wcnt_reg   <= '0;
            round_reg  <= '0;
            strobe_reg <= 1'b0;
            for (int i = 0; i < 4; i++) key_reg[i] <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            strobe_reg <= strobe_next;
            // a key write drops the expanded keys
            if (cfg_valid && cfg_ready)
            begin
                key_reg[cfg_index] <= cfg_data;
                kvalid_reg         <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        step_reg  <= '0;
                        wcnt_reg  <= '0;
                        round_reg <= '0;
                    end
                end
                S_KWR:
                begin
                    wcnt_reg <= wcnt_reg + 2'd1;
                    if (wcnt_reg == 2'd3 && step_reg == 6'(4 * (kuz_pkg::KEY_COUNT - 2)))
                        kvalid_reg <= 1'b1;
                end
                S_KFW:
                begin
                    if (l_done) step_reg <= step_reg + 6'd1;
                end
                S_LWAIT:
                begin
                    if (l_done) round_reg <= round_reg + 4'd1;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg  <= request.op;
            blk_reg <= {request.block_in_high, request.block_in_low};
            h0_reg  <= {key_reg[3], key_reg[2]};
            h1_reg  <= {key_reg[1], key_reg[0]};
        end
        if (state_reg == S_KCW && l_done) c_reg <= l_dout;
        if (state_reg == S_KFW && l_done)
        begin
            if (step_reg[0]) h0_reg <= h0_reg ^ l_dout;
            else             h1_reg <= h1_reg ^ l_dout;
        end
        if (state_reg == S_RD1) klo_reg <= rdata;
        if (state_reg == S_LGO && last_round) blk_reg <= kin;
        if (state_reg == S_LWAIT && l_done)
            blk_reg <= op_reg ? kuz_pkg::sub_inv(l_dout) : l_dout;
    end

    assign result = '{block_out_low: blk_reg[63:0], block_out_high: blk_reg[127:64]};

    a_strobe_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |=> !strobe);
    a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> !busy);
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy);
    a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg));
endmodule
